>>> rtl/vczc_pkg.sv
`default_nettype none

package vczc_pkg;

  // default build of the block
  localparam int WINDOW_LENGTH_DEF = 20;
  localparam int SAMPLE_BITS_DEF   = 10;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // register widths
  localparam int LEVEL_W = 9;
  localparam int GAP_W   = 10;
  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register reset values
  localparam int LEVEL_RESET          = 30;
  localparam logic [GAP_W-1:0]   GAP_RESET      = GAP_W'(200);
  localparam logic [COUNT_W-1:0] BAND_ONE_LO    = COUNT_W'(160);
  localparam logic [COUNT_W-1:0] BAND_ONE_HI    = COUNT_W'(250);
  localparam logic [COUNT_W-1:0] BAND_TWO_LO    = COUNT_W'(57);
  localparam logic [COUNT_W-1:0] BAND_TWO_HI    = COUNT_W'(97);
  localparam logic [COUNT_W-1:0] BAND_THREE_LO  = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] BAND_THREE_HI  = COUNT_W'(150);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_GAP_LIMIT       = 3'd1,
    REG_BAND_ONE_LOW    = 3'd2,
    REG_BAND_ONE_HIGH   = 3'd3,
    REG_BAND_TWO_LOW    = 3'd4,
    REG_BAND_TWO_HIGH   = 3'd5,
    REG_BAND_THREE_LOW  = 3'd6,
    REG_BAND_THREE_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ONE   = 2'd1,
    CMD_TWO   = 2'd2,
    CMD_THREE = 2'd3
  } cmd_t;

  // registers seen by the clip controller
  typedef struct packed {
    logic [GAP_W-1:0]   gap_limit;
    logic [COUNT_W-1:0] band_one_low;
    logic [COUNT_W-1:0] band_one_high;
    logic [COUNT_W-1:0] band_two_low;
    logic [COUNT_W-1:0] band_two_high;
    logic [COUNT_W-1:0] band_three_low;
    logic [COUNT_W-1:0] band_three_high;
  } ctrl_regs_t;

  // one result beat
  typedef struct packed {
    logic               clip_active;
    cmd_t               command_code;
    logic [COUNT_W-1:0] crossing_total;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/vczc_cell.sv
`default_nettype none

module vczc_cell import vczc_pkg::*; #(
  parameter int MAG_W = SAMPLE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic             clear,
  input  wire logic [MAG_W-1:0] mag_in,
  output logic      [MAG_W-1:0] mag_out
);

  logic [MAG_W-1:0] mag_r;

  // clear wins over a shift on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      mag_r <= '0;
    end else if (shift_en) begin
      mag_r <= mag_in;
    end
  end

  assign mag_out = mag_r;

endmodule

`default_nettype wire

>>> rtl/vczc_ctrl.sv
`default_nettype none

module vczc_ctrl import vczc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       voiced,
  input  wire logic       cur_pos,
  input  wire logic       cur_neg,
  input  wire ctrl_regs_t regs,
  output logic            clear_all,
  output result_t         result
);

  logic               in_clip_r, in_clip_nxt;
  logic [GAP_W-1:0]   quiet_run_r, quiet_run_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               prev_pos_r, prev_pos_nxt;
  logic               prev_neg_r, prev_neg_nxt;

  logic               change;
  logic [COUNT_W-1:0] count_inc;
  logic [GAP_W:0]     quiet_inc;
  logic               hit_one, hit_two, hit_three;
  cmd_t               cmd;

  assign change    = (cur_pos && prev_neg_r) || (cur_neg && prev_pos_r);
  assign count_inc = (change && count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign quiet_inc = {1'b0, quiet_run_r} + (GAP_W+1)'(1);

  assign hit_one   = count_r > regs.band_one_low   && count_r < regs.band_one_high;
  assign hit_two   = count_r > regs.band_two_low   && count_r < regs.band_two_high;
  assign hit_three = count_r > regs.band_three_low && count_r < regs.band_three_high;

  always_comb begin
    in_clip_nxt   = in_clip_r;
    quiet_run_nxt = quiet_run_r;
    count_nxt     = count_r;
    prev_pos_nxt  = prev_pos_r;
    prev_neg_nxt  = prev_neg_r;
    cmd           = CMD_NONE;
    clear_all     = 1'b0;

    if (voiced || in_clip_r) begin
      // count the crossing, then track the clip
      count_nxt    = count_inc;
      prev_pos_nxt = cur_pos;
      prev_neg_nxt = cur_neg;
      if (voiced) begin
        in_clip_nxt   = 1'b1;
        quiet_run_nxt = '0;
      end else if (quiet_inc > {1'b0, regs.gap_limit}) begin
        in_clip_nxt   = 1'b0;
        quiet_run_nxt = '0;
      end else begin
        quiet_run_nxt = quiet_inc[GAP_W-1:0];
      end
    end else begin
      // quiet outside a clip: classify the finished count
      if (hit_one) begin
        cmd = CMD_ONE;
      end else if (hit_two) begin
        cmd = CMD_TWO;
      end else if (hit_three) begin
        cmd = CMD_THREE;
      end
      if (cmd != CMD_NONE) begin
        clear_all = accept;
        prev_pos_nxt = 1'b0;
        prev_neg_nxt = 1'b0;
      end
      count_nxt = '0;
    end

    result.clip_active    = in_clip_nxt;
    result.command_code   = cmd;
    result.crossing_total = (cmd != CMD_NONE) ? count_r : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_clip_r   <= 1'b0;
      quiet_run_r <= '0;
      count_r     <= '0;
      prev_pos_r  <= 1'b0;
      prev_neg_r  <= 1'b0;
    end else if (accept) begin
      in_clip_r   <= in_clip_nxt;
      quiet_run_r <= quiet_run_nxt;
      count_r     <= count_nxt;
      prev_pos_r  <= prev_pos_nxt;
      prev_neg_r  <= prev_neg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vczc_out_buf.sv
`default_nettype none

module vczc_out_buf import vczc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    out_stall,
  output logic         full,
  output logic         out_valid,
  output result_t      out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    out_free;

  // output register can take a new beat
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || load;
      skid_valid_r <= 1'b0;
    end else if (load) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : load_data;
    end else if (load) begin
      skid_data_r <= load_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/voice_clip_zero_cross_classifier.sv
`default_nettype none

// a result beat is registered in the output stage, or its skid entry, as its sample
// is taken; throughput: one sample per cycle while in_stall is low; the window sum,
// threshold compare and clip controller all settle in the accepting cycle, and a
// two-entry output stage keeps taking samples while one result waits under out_stall
// reset (rst_n low at a clock edge): window, sum, clip state and output stage clear,
// registers return to their default values
module voice_clip_zero_cross_classifier import vczc_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // sample channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_value,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_clip_active,
  output logic [1:0]                  out_command_code,
  output logic [COUNT_W-1:0]          out_crossing_total,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // magnitude reaches 2^(SAMPLE_BITS-1), so it needs the full sample width
  localparam int MAG_W = SAMPLE_BITS;
  localparam int SUM_W = MAG_W + $clog2(WINDOW_LENGTH);
  // scaled threshold (level + 1) * WINDOW_LENGTH
  localparam int THR_W = LEVEL_W + 1 + $clog2(WINDOW_LENGTH);
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'((LEVEL_RESET + 1) * WINDOW_LENGTH);

  // ---------------------------------------------------------------------------
  // registers
  // floor(sum / N) > level  is the same as  sum >= (level + 1) * N, so the
  // level register is kept pre-scaled and no divider sits in the sample path
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] thr_scaled_r;
  ctrl_regs_t       regs_r;
  logic             cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_scaled_r           <= THR_RESET;
      regs_r.gap_limit       <= GAP_RESET;
      regs_r.band_one_low    <= BAND_ONE_LO;
      regs_r.band_one_high   <= BAND_ONE_HI;
      regs_r.band_two_low    <= BAND_TWO_LO;
      regs_r.band_two_high   <= BAND_TWO_HI;
      regs_r.band_three_low  <= BAND_THREE_LO;
      regs_r.band_three_high <= BAND_THREE_HI;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_LEVEL_THRESHOLD: begin
          thr_scaled_r <= THR_W'((THR_W'(cfg_data[LEVEL_W-1:0]) + THR_W'(1))
                                 * THR_W'(WINDOW_LENGTH));
        end
        REG_GAP_LIMIT:       regs_r.gap_limit       <= cfg_data[GAP_W-1:0];
        REG_BAND_ONE_LOW:    regs_r.band_one_low    <= cfg_data[COUNT_W-1:0];
        REG_BAND_ONE_HIGH:   regs_r.band_one_high   <= cfg_data[COUNT_W-1:0];
        REG_BAND_TWO_LOW:    regs_r.band_two_low    <= cfg_data[COUNT_W-1:0];
        REG_BAND_TWO_HIGH:   regs_r.band_two_high   <= cfg_data[COUNT_W-1:0];
        REG_BAND_THREE_LOW:  regs_r.band_three_low  <= cfg_data[COUNT_W-1:0];
        REG_BAND_THREE_HIGH: regs_r.band_three_high <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sample front end: centre about mid-scale, magnitude and sign
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             buf_full;
  logic [MAG_W-1:0] mag;
  logic             cur_pos;
  logic             cur_neg;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // upper half: sample - mid is just the low bits; lower half: mid - sample
  assign mag = in_sample_value[SAMPLE_BITS-1]
             ? {1'b0, in_sample_value[SAMPLE_BITS-2:0]}
             : MAG_W'({1'b1, {(SAMPLE_BITS-1){1'b0}}} - in_sample_value);
  assign cur_pos = in_sample_value[SAMPLE_BITS-1] && (|in_sample_value[SAMPLE_BITS-2:0]);
  assign cur_neg = !in_sample_value[SAMPLE_BITS-1];

  // ---------------------------------------------------------------------------
  // magnitude window: a shift chain of cells, the last one is the oldest entry
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] chain [WINDOW_LENGTH+1];
  logic             clear_all;

  assign chain[0] = mag;

  for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
    vczc_cell #(
      .MAG_W (MAG_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .clear    (clear_all),
      .mag_in   (chain[g]),
      .mag_out  (chain[g+1])
    );
  end

  // running sum: add the new magnitude, drop the one leaving the window
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_calc;
  logic             voiced;

  assign sum_calc = sum_r + SUM_W'(mag) - SUM_W'(chain[WINDOW_LENGTH]);
  assign voiced   = CMP_W'(sum_calc) >= CMP_W'(thr_scaled_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      sum_r <= '0;
    end else if (accept) begin
      sum_r <= sum_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // clip tracking, crossing count and band match
  // ---------------------------------------------------------------------------
  result_t result;

  vczc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .voiced    (voiced),
    .cur_pos   (cur_pos),
    .cur_neg   (cur_neg),
    .regs      (regs_r),
    .clear_all (clear_all),
    .result    (result)
  );

  // ---------------------------------------------------------------------------
  // output register with skid entry; stall back to the sample side only when
  // both hold a beat
  // ---------------------------------------------------------------------------
  result_t out_data;

  vczc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (result),
    .out_stall (out_stall),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_clip_active    = out_data.clip_active;
  assign out_command_code   = out_data.command_code;
  assign out_crossing_total = out_data.crossing_total;

endmodule

`default_nettype wire

>>> tb/sv/tb_voice_clip_zero_cross_classifier.sv
`default_nettype none

module tb_voice_clip_zero_cross_classifier;
  import vczc_pkg::*;

  localparam int WIN_LEN     = WINDOW_LENGTH_DEF;
  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int MID         = 1 << (SAMPLE_W - 1);
  // cycles with no beat on any channel before the run is declared hung;
  // random stalls at one in four never come close to this
  localparam int STUCK_LIMIT = 2000;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // sample channel
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_value = '0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_clip_active;
  logic [1:0]         out_command_code;
  logic [COUNT_W-1:0] out_crossing_total;

  // register write channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index = REG_LEVEL_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  voice_clip_zero_cross_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_clip_active    (out_clip_active),
    .out_command_code   (out_command_code),
    .out_crossing_total (out_crossing_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // samples waiting to be driven, and results still owed by the block
  logic [SAMPLE_W-1:0] sample_backlog[$];
  result_t             owed_results[$];

  // run control, set by the stimulus process
  bit throttle_on = 1'b1;   // random idling on both channels
  bit sender_hold = 1'b0;   // sender parks until the block has drained

  int issued_samples   = 0;
  int accepted_samples = 0;
  int error_count      = 0;
  int cfg_writes       = 0;
  int cmd_seen[4]      = '{0, 0, 0, 0};
  int stuck_cycles     = 0;

  // ---------------------------------------------------------------------------
  // classifier tracking: registers and clip state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] level_reg;
  int gap_reg;
  int band_lo[3];
  int band_hi[3];

  int mag_hist[WIN_LEN];
  int hist_pos;
  int mag_sum;
  bit clip_open;
  int quiet_len;
  int zc_count;
  int last_centred;

  function automatic void clear_tracker();
    foreach (mag_hist[i]) mag_hist[i] = 0;
    hist_pos     = 0;
    mag_sum      = 0;
    clip_open    = 1'b0;
    quiet_len    = 0;
    zc_count     = 0;
    last_centred = 0;
  endfunction

  function automatic void load_default_regs();
    level_reg  = LEVEL_W'(LEVEL_RESET);
    gap_reg    = int'(GAP_RESET);
    band_lo[0] = int'(BAND_ONE_LO);
    band_hi[0] = int'(BAND_ONE_HI);
    band_lo[1] = int'(BAND_TWO_LO);
    band_hi[1] = int'(BAND_TWO_HI);
    band_lo[2] = int'(BAND_THREE_LO);
    band_hi[2] = int'(BAND_THREE_HI);
  endfunction

  // strict sign change against the last sample seen inside a clip
  function automatic void note_crossing(input int centred);
    if (((centred > 0 && last_centred < 0) || (centred < 0 && last_centred > 0)) &&
        zc_count < int'(COUNT_MAX))
      zc_count++;
    last_centred = centred;
  endfunction

  function automatic result_t classify_sample(input logic [SAMPLE_W-1:0] sample);
    int      centred;
    int      mag;
    int      avg;
    int      total;
    cmd_t    code;
    result_t res;
    centred  = int'(sample) - MID;
    mag      = (centred < 0) ? -centred : centred;
    mag_sum  = mag_sum - mag_hist[hist_pos] + mag;
    mag_hist[hist_pos] = mag;
    hist_pos = (hist_pos + 1) % WIN_LEN;
    avg      = mag_sum / WIN_LEN;
    code     = CMD_NONE;
    if (avg > int'(level_reg)) begin
      // voiced: open or extend the clip
      clip_open = 1'b1;
      quiet_len = 0;
      note_crossing(centred);
      total = zc_count;
    end else if (clip_open) begin
      // quiet inside a clip: close it once the gap is exceeded
      if (quiet_len + 1 > gap_reg) begin
        clip_open = 1'b0;
        quiet_len = 0;
      end else begin
        quiet_len++;
      end
      note_crossing(centred);
      total = zc_count;
    end else begin
      // quiet outside a clip: bands in priority order, one first
      if (zc_count > band_lo[0] && zc_count < band_hi[0])
        code = CMD_ONE;
      else if (zc_count > band_lo[1] && zc_count < band_hi[1])
        code = CMD_TWO;
      else if (zc_count > band_lo[2] && zc_count < band_hi[2])
        code = CMD_THREE;
      if (code != CMD_NONE) begin
        total = zc_count;
        clear_tracker();
      end else begin
        zc_count = 0;
        total    = 0;
      end
    end
    res.clip_active    = clip_open;
    res.command_code   = code;
    res.crossing_total = COUNT_W'(total);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: one beat per queued sample, random idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // stalled beat stays as it is
    end else if (sample_backlog.size() > 0 && !sender_hold &&
                 !(throttle_on && $urandom_range(99) < 25)) begin
      in_valid        <= 1'b1;
      in_sample_value <= sample_backlog.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every sample beat, checks every result beat,
  // and drives the result stall
  // ---------------------------------------------------------------------------
  function automatic void flag_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_valid && !in_stall) begin
      owed_results.push_back(classify_sample(in_sample_value));
      accepted_samples++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing pending, actual clip %0d cmd %0d total %0d",
                 $time, out_clip_active, out_command_code, out_crossing_total);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        cmd_seen[want.command_code]++;
        flag_field("clip_active", want.clip_active, out_clip_active);
        flag_field("command_code", want.command_code, out_command_code);
        flag_field("crossing_total", want.crossing_total, out_crossing_total);
      end
    end
    out_stall <= throttle_on && ($urandom_range(99) < 25);
  end

  // hang detection: any beat on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still owed",
               $time, STUCK_LIMIT, owed_results.size());
      $display("tb_voice_clip_zero_cross_classifier failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_sample(input int value);
    sample_backlog.push_back(SAMPLE_W'(value));
    issued_samples++;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // upper data bits beyond a register's width are dropped
    case (idx)
      REG_LEVEL_THRESHOLD: level_reg  = data[LEVEL_W-1:0];
      REG_GAP_LIMIT:       gap_reg    = int'(data);
      REG_BAND_ONE_LOW:    band_lo[0] = int'(data);
      REG_BAND_ONE_HIGH:   band_hi[0] = int'(data);
      REG_BAND_TWO_LOW:    band_lo[1] = int'(data);
      REG_BAND_TWO_HIGH:   band_hi[1] = int'(data);
      REG_BAND_THREE_LOW:  band_lo[2] = int'(data);
      REG_BAND_THREE_HIGH: band_hi[2] = int'(data);
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input int level, input int gap, input int b1l, input int b1h,
                              input int b2l, input int b2h, input int b3l, input int b3h);
    write_reg(REG_LEVEL_THRESHOLD, level);
    write_reg(REG_GAP_LIMIT, gap);
    write_reg(REG_BAND_ONE_LOW, b1l);
    write_reg(REG_BAND_ONE_HIGH, b1h);
    write_reg(REG_BAND_TWO_LOW, b2l);
    write_reg(REG_BAND_TWO_HIGH, b2h);
    write_reg(REG_BAND_THREE_LOW, b3l);
    write_reg(REG_BAND_THREE_HIGH, b3h);
  endtask

  // block idle: every queued sample taken and every result back
  task automatic wait_drained();
    while (!(accepted_samples == issued_samples && owed_results.size() == 0))
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one utterance: loud burst with random sign flips, then a quiet tail
  // near mid-scale (exact silence when the threshold is tiny)
  task automatic add_clip(input int burst_len, input int tail_len);
    bit up;
    int amp_lo;
    int m;
    int q;
    up     = $urandom_range(1);
    amp_lo = (int'(level_reg) + 1 > 511) ? 511 : int'(level_reg) + 1;
    q      = (level_reg > 3) ? 3 : 0;
    for (int i = 0; i < burst_len; i++) begin
      if ($urandom_range(99) < 60) up = !up;
      m = int'($urandom_range(511, amp_lo));
      push_sample(up ? MID + m : MID - m);
    end
    for (int i = 0; i < tail_len; i++)
      push_sample(MID + int'($urandom_range(2 * q)) - q);
  endtask

  // mostly complete utterances, some cut short, some raw noise
  task automatic run_mix(input int n_items);
    int target;
    int r;
    int gap_part;
    target   = issued_samples + n_items;
    gap_part = (gap_reg > 40) ? 40 : gap_reg;
    while (issued_samples < target) begin
      r = $urandom_range(99);
      if (r < 70)
        add_clip($urandom_range(60, 4), gap_part + WIN_LEN + $urandom_range(6, 1));
      else if (r < 85)
        add_clip($urandom_range(30, 1), $urandom_range(gap_part + 2, 0));
      else
        repeat ($urandom_range(8, 1)) push_sample($urandom_range(1023));
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    load_default_regs();
    clear_tracker();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: silence, a window sitting exactly on the
    // threshold, then sign changes including through an exact zero
    push_sample(512);
    push_sample(0);
    push_sample(424);
    push_sample(1023);
    push_sample(0);
    push_sample(1023);
    push_sample(512);
    push_sample(1023);
    push_sample(1);
    push_sample(511);
    push_sample(513);
    wait_drained();

    // top threshold with upper data bit masked off, zero gap,
    // inverted and empty bands, band three covering every count from 1 to 1022
    program_regs(10'h3FF, 0, 5, 3, 6, 7, 0, 1023);
    repeat (WIN_LEN) push_sample(0);
    push_sample(1023);
    push_sample(512);
    wait_drained();

    // band limits overlap, yet no count hits two; sender parks once midway
    program_regs(40, 3, 2, 12, 11, 25, 24, 60);
    run_mix(30);
    while (accepted_samples < issued_samples - 20) @(posedge clk);
    sender_hold = 1'b1;
    repeat (2) @(posedge clk);
    while (in_valid || owed_results.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
    run_mix(30);
    wait_drained();

    // zero threshold (written with an unused bit set)
    program_regs(10'h200, 5, 8, 30, 29, 50, 49, 120);
    run_mix(30);
    wait_drained();

    // widest gap: clips never close here
    program_regs($urandom_range(60, 15), 1023, $urandom_range(40), $urandom_range(80),
                 $urandom_range(40), $urandom_range(80), $urandom_range(40),
                 $urandom_range(80));
    run_mix(20);
    wait_drained();

    // alternating full-scale burst with no idling: back to back beats
    throttle_on = 1'b0;
    program_regs(12, 2, 1020, 1023, 0, 1, 40, 45);
    for (int i = 0; i < 64; i++) push_sample((i % 2) ? 1023 : 0);
    repeat (30) push_sample(512);
    wait_drained();
    throttle_on = 1'b1;

    // two random register sets, some bands inverted by chance
    repeat (2) begin
      program_regs($urandom_range(90, 15), $urandom_range(10), $urandom_range(50),
                   $urandom_range(90), $urandom_range(50), $urandom_range(90),
                   $urandom_range(50), $urandom_range(90));
      run_mix(20);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("run covered %0d samples over %0d register writes, incl. an unthrottled burst",
             accepted_samples, cfg_writes);
    $display("commands seen: none %0d, one %0d, two %0d, three %0d",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    if (error_count == 0) begin
      $display("tb_voice_clip_zero_cross_classifier passed");
    end else begin
      $display("tb_voice_clip_zero_cross_classifier failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
